@@ rtl/core/tvi_pkg.sv @@
// Package for the trilinear vector interpolator.
// Operation codes, the plane count and shared types; no dependencies.
`default_nettype none
package tvi_pkg;
  localparam logic [1:0] OP_LOAD_CORNER = 2'd0;
  localparam logic [1:0] OP_LOAD_PLANE  = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;
  localparam int unsigned NUM_PLANES    = 6;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

@@ rtl/core/tvi_if.sv @@
// Valid/ready channel interfaces for the interpolator.
// Depends on nothing; payload widths are fixed Q16.16 fields.
`default_nettype none
interface tvi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [2:0]  slot;
  logic signed [31:0] val_x;
  logic signed [31:0] val_y;
  logic signed [31:0] val_z;
  logic signed [31:0] coord;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, operation, slot, val_x, val_y, val_z, coord,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, operation, slot, val_x, val_y, val_z, coord,
                pos_x, pos_y, pos_z, output ready);
endinterface

interface tvi_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic        span_error;
  modport source (output valid, out_x, out_y, out_z, span_error, input ready);
  modport sink (input valid, out_x, out_y, out_z, span_error, output ready);
endinterface
`default_nettype wire

@@ rtl/core/trilinear_vector_interpolator.sv @@
// Trilinear vector interpolator: top level with store and step sequencer.
// Depends on tvi_pkg, tvi_if and tvi_div.
// Loads are written as they are accepted. A query runs 7 steps x 3 components, each
// through span, division, multiply and add states (a zero span skips the division and
// the multiply); the result register then takes the result. A waiting result does not
// block input, but a later query stays busy until it is taken. Reset clears control state only; store undefined.
`default_nettype none
module trilinear_vector_interpolator
  import tvi_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tvi_in_if.sink    in_if,
  tvi_out_if.source out_if
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned IW = 2 * DATA_WIDTH + 2;
  localparam logic signed [IW-1:0] VMAX = IW'((65'sd1 <<< (W - 1)) - 1);
  localparam logic signed [IW-1:0] VMIN = -VMAX - IW'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SPAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  function automatic logic signed [W-1:0] sat_f(input logic signed [IW-1:0] v);
    if (v > VMAX) return VMAX[W-1:0];
    if (v < VMIN) return VMIN[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] fin_f(input logic signed [31:0] v);
    return sat_f(IW'(v));
  endfunction

  logic signed [W-1:0] vec_q [8][3];
  logic signed [W-1:0] hgt_q [8];
  logic signed [W-1:0] pln_q [NUM_PLANES];
  // working values: 0..3 columns, 4..5 rows, 6 result
  logic signed [W-1:0] wrk_q [7][3];
  logic signed [W-1:0] px_q, py_q, pz_q;

  logic [2:0]  state_q, state_d;
  logic [2:0]  step_q;
  logic [1:0]  comp_q;
  logic        err_q;
  logic signed [W-1:0] span_q, off_q, ratio_q, a_q;
  logic signed [IW-1:0] prod_q;
  logic        ovalid_q;
  logic signed [W-1:0] ox_q, oy_q, oz_q;
  logic        oerr_q;

  // operand selection for the current step
  logic signed [W-1:0] a_s, b_s, pa_s, pb_s, pos_s;
  always_comb begin
    a_s = '0; b_s = '0; pa_s = '0; pb_s = '0; pos_s = '0;
    case (step_q)
      3'd0, 3'd1, 3'd2, 3'd3: begin
        a_s  = vec_q[{step_q[1:0], 1'b0}][comp_q];
        b_s  = vec_q[{step_q[1:0], 1'b1}][comp_q];
        pa_s = hgt_q[{step_q[1:0], 1'b0}];
        pb_s = hgt_q[{step_q[1:0], 1'b1}];
        pos_s = pz_q;
      end
      3'd4: begin
        a_s = wrk_q[0][comp_q]; b_s = wrk_q[1][comp_q];
        pa_s = pln_q[0]; pb_s = pln_q[1]; pos_s = px_q;
      end
      3'd5: begin
        a_s = wrk_q[2][comp_q]; b_s = wrk_q[3][comp_q];
        pa_s = pln_q[2]; pb_s = pln_q[3]; pos_s = px_q;
      end
      default: begin
        a_s = wrk_q[4][comp_q]; b_s = wrk_q[5][comp_q];
        pa_s = pln_q[4]; pb_s = pln_q[5]; pos_s = py_q;
      end
    endcase
  end

  logic signed [W-1:0]  diff_s;
  logic signed [IW-1:0] num_s;
  logic signed [IW-1:0] quo_s;
  div_ctl_t             dctl;
  logic                 div_start;
  assign diff_s = sat_f(IW'(b_s) - IW'(a_s));
  assign num_s  = IW'(diff_s) <<< FRAC_BITS;
  // a zero span never starts the divider
  assign div_start = (state_q == S_DIV) && (span_q != '0);

  tvi_div #(.NUM_W(IW), .DEN_W(W)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(num_s), .den_i(span_q),
    .ctl_o(dctl), .quo_o(quo_s)
  );

  // 32 x 32 signed product
  logic signed [2*W-1:0] mul_s;
  assign mul_s = ratio_q * off_q;

  logic signed [IW-1:0] stepv_s;
  logic signed [IW-1:0] pabs_s;
  assign pabs_s  = prod_q[IW-1] ? -prod_q : prod_q;
  assign stepv_s = prod_q[IW-1] ? -(pabs_s >>> FRAC_BITS) : (pabs_s >>> FRAC_BITS);

  wire in_fire  = in_if.valid && in_if.ready;
  wire out_fire = out_if.valid && out_if.ready;
  // result register takes the new result once it is free or being drained
  wire out_load = (state_q == S_OUT) && (!ovalid_q || out_fire);
  assign in_if.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire && in_if.operation == OP_QUERY) state_d = S_SPAN;
      S_SPAN: state_d = S_DIV;
      S_DIV:  state_d = (span_q == '0) ? S_ADD : S_WAIT;
      S_WAIT: if (dctl.done) state_d = S_MUL;
      S_MUL:  state_d = S_ADD;
      S_ADD:  state_d = (step_q == 3'd6 && comp_q == 2'd2) ? S_OUT : S_SPAN;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      comp_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) begin
        step_q <= '0;
        comp_q <= '0;
      end else if (state_q == S_ADD) begin
        if (comp_q == 2'd2) begin
          comp_q <= '0;
          step_q <= step_q + 1'b1;
        end else begin
          comp_q <= comp_q + 1'b1;
        end
      end
      if (out_load) ovalid_q <= 1'b1;
      else if (out_fire) ovalid_q <= 1'b0;
    end
  end

  // store, datapath and result registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      case (in_if.operation)
        OP_LOAD_CORNER: begin
          vec_q[in_if.slot][0] <= fin_f(in_if.val_x);
          vec_q[in_if.slot][1] <= fin_f(in_if.val_y);
          vec_q[in_if.slot][2] <= fin_f(in_if.val_z);
          hgt_q[in_if.slot]    <= fin_f(in_if.coord);
        end
        OP_LOAD_PLANE:
          if (in_if.slot < 3'(NUM_PLANES)) pln_q[in_if.slot] <= fin_f(in_if.coord);
        OP_QUERY: begin
          px_q  <= fin_f(in_if.pos_x);
          py_q  <= fin_f(in_if.pos_y);
          pz_q  <= fin_f(in_if.pos_z);
          err_q <= 1'b0;
        end
        default: ;
      endcase
    end
    case (state_q)
      S_SPAN: begin
        span_q <= sat_f(IW'(pb_s) - IW'(pa_s));
        off_q  <= sat_f(IW'(pos_s) - IW'(pa_s));
        a_q    <= a_s;
      end
      S_DIV: if (span_q == '0) begin
        err_q   <= 1'b1;
        prod_q  <= '0;
      end
      S_WAIT: if (dctl.done) ratio_q <= sat_f(quo_s);
      S_MUL:  prod_q <= IW'(mul_s);
      S_ADD:  wrk_q[step_q][comp_q] <= sat_f(IW'(a_q) + IW'(sat_f(stepv_s)));
      S_OUT: if (out_load) begin
        ox_q   <= wrk_q[6][0];
        oy_q   <= wrk_q[6][1];
        oz_q   <= wrk_q[6][2];
        oerr_q <= err_q;
      end
      default: ;
    endcase
  end

  assign out_if.valid      = ovalid_q;
  assign out_if.out_x      = 32'(ox_q);
  assign out_if.out_y      = 32'(oy_q);
  assign out_if.out_z      = 32'(oz_q);
  assign out_if.span_error = oerr_q;
endmodule
`default_nettype wire

@@ rtl/core/tvi_div.sv @@
// Restoring signed divider, one quotient bit per cycle.
// Depends on tvi_pkg; quotient truncated toward zero.
`default_nettype none
module tvi_div
  import tvi_pkg::*;
#(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic signed [DEN_W-1:0] den_i,
  output div_ctl_t                     ctl_o,
  output logic signed [NUM_W-1:0]      quo_o
);
  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic             neg_q, neg_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    trial   = shifted - {1'b0, den_q};
    if (start_i && !busy_q) begin
      quo_d  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      den_d  = den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
      neg_d  = num_i[NUM_W-1] ^ den_i[DEN_W-1];
      rem_d  = '0;
      cnt_d  = CW'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one numerator bit, subtract when it fits
      if (!trial[DEN_W]) begin
        rem_d = trial;
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign quo_o = neg_q ? NUM_W'(-quo_q) : quo_q;
  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};
endmodule
`default_nettype wire

@@ rtl/core/tvi_checker.sv @@
// Port-level checker for the trilinear vector interpolator, bound to the top.
// Depends on tvi_pkg for operation codes.
`default_nettype none
module tvi_checker
  import tvi_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic [1:0] in_op,
  input wire logic out_valid,
  input wire logic out_ready
);
  // a query never produces a result in the very next cycle
  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_op == OP_QUERY && !out_valid |=> !out_valid)
    else $error("result too early");
  // handshake controls are always driven
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready, out_valid})) else $error("unknown handshake");
  // a query makes the block busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_op == OP_QUERY |=> !in_ready)
    else $error("ready after query");
  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind trilinear_vector_interpolator tvi_checker u_tvi_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready), .in_op(in_if.operation),
  .out_valid(out_if.valid), .out_ready(out_if.ready)
);
`default_nettype wire

@@ tb/trilinear_vector_interpolator_tb.sv @@
// Self-checking testbench for the trilinear vector interpolator.
// Depends on tvi_pkg, tvi_if and the block; a directed table then random traffic.
`timescale 1ns / 100ps
module trilinear_vector_interpolator_tb;
  import tvi_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint ONE_Q = 64'sd65536;
  localparam int RAND_ITEMS = 1400;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 8000;
  localparam int DRAIN_CYCLES = 2000;

  typedef struct {
    logic [1:0]         op;
    logic [2:0]         slot;
    logic signed [31:0] vx, vy, vz, coord, px, py, pz;
    bit                 typed;
    logic signed [31:0] ex, ey, ez;
    logic               eerr;
  } stim_row_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               err;
  } interp_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tvi_in_if  in_if ();
  tvi_out_if out_if ();

  trilinear_vector_interpolator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  // shadow store of the block
  longint corner_vec [8][3];
  longint corner_hgt [8];
  longint plane_pos [6];
  interp_res_t pending_results [$];
  int errors = 0;
  int results_seen = 0;
  stim_row_t dir_rows [$];

  function automatic longint clamp32(input longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  // one linear step for all three components
  task automatic lerp3(input longint a [3], input longint b [3], input longint pa,
                       input longint pb, input longint pos, output longint r [3],
                       inout bit err);
    longint span, off, d, ratio, stp;
    span = clamp32(pb - pa);
    off = clamp32(pos - pa);
    if (span == 0) begin
      err = 1'b1;
      for (int i = 0; i < 3; i++) r[i] = a[i];
    end else begin
      for (int i = 0; i < 3; i++) begin
        d = clamp32(b[i] - a[i]);
        ratio = clamp32((d * ONE_Q) / span);
        stp = clamp32((ratio * off) / ONE_Q);
        r[i] = clamp32(a[i] + stp);
      end
    end
  endtask

  // apply one accepted transaction to the shadow store; queue a result for queries
  task automatic predict_interp(input stim_row_t t, input bit use_typed);
    longint col [4][3];
    longint row [2][3];
    longint res [3];
    bit err;
    interp_res_t e;
    err = 1'b0;
    case (t.op)
      OP_LOAD_CORNER: begin
        corner_vec[t.slot][0] = t.vx;
        corner_vec[t.slot][1] = t.vy;
        corner_vec[t.slot][2] = t.vz;
        corner_hgt[t.slot] = t.coord;
      end
      OP_LOAD_PLANE: begin
        if (t.slot < NUM_PLANES) plane_pos[t.slot] = t.coord;
      end
      OP_QUERY: begin
        for (int i = 0; i < 4; i++)
          lerp3(corner_vec[2*i], corner_vec[2*i+1], corner_hgt[2*i], corner_hgt[2*i+1],
                longint'(t.pz), col[i], err);
        lerp3(col[0], col[1], plane_pos[0], plane_pos[1], longint'(t.px), row[0], err);
        lerp3(col[2], col[3], plane_pos[2], plane_pos[3], longint'(t.px), row[1], err);
        lerp3(row[0], row[1], plane_pos[4], plane_pos[5], longint'(t.py), res, err);
        if (use_typed) begin
          e.x = t.ex; e.y = t.ey; e.z = t.ez; e.err = t.eerr;
        end else begin
          e.x = res[0][31:0]; e.y = res[1][31:0]; e.z = res[2][31:0]; e.err = err;
        end
        pending_results = {pending_results, e};
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got,
             want);
  endtask

  // result monitor
  always @(posedge clk_i) begin
    interp_res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_if.out_x !== e.x) report_mismatch("out_x", out_if.out_x, e.x);
        if (out_if.out_y !== e.y) report_mismatch("out_y", out_if.out_y, e.y);
        if (out_if.out_z !== e.z) report_mismatch("out_z", out_if.out_z, e.z);
        if (out_if.span_error !== e.err)
          report_mismatch("span_error", out_if.span_error, e.err);
      end
      results_seen++;
    end
  end

  // watchdog on cycles without any accepted transaction
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return VMAX[31:0];
      2: return VMIN[31:0];
      default: return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? VMAX[31:0] : VMIN[31:0];
      2: return ($signed($urandom_range(0, 8)) - 4) * 65536;
      default: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endcase
  endfunction

  function automatic stim_row_t rand_item();
    stim_row_t t;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) t.op = OP_LOAD_CORNER;
    else if (pick < 62) t.op = OP_LOAD_PLANE;
    else if (pick < 95) t.op = OP_QUERY;
    else t.op = OP_RESERVED;
    t.slot = 3'($urandom_range(0, 7));
    t.vx = rand_val(); t.vy = rand_val(); t.vz = rand_val();
    t.coord = rand_coord();
    t.px = rand_coord(); t.py = rand_coord(); t.pz = rand_coord();
    t.typed = 1'b0;
    t.ex = '0; t.ey = '0; t.ez = '0; t.eerr = 1'b0;
    return t;
  endfunction

  function automatic stim_row_t mk(input logic [1:0] op, input logic [2:0] slot,
                                   input logic signed [31:0] v0, v1, v2, c, p0, p1, p2);
    stim_row_t t;
    t.op = op; t.slot = slot; t.vx = v0; t.vy = v1; t.vz = v2; t.coord = c;
    t.px = p0; t.py = p1; t.pz = p2;
    t.typed = 1'b0; t.ex = '0; t.ey = '0; t.ez = '0; t.eerr = 1'b0;
    return t;
  endfunction

  bit hold_done = 1'b0;

  // receiver: random stalls, stall-free phases, one long hold-off
  initial begin
    int w;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && results_seen >= 6) begin
        hold_done = 1'b1;
        w = LONG_HOLD;
      end else if (((results_seen / 20) % 3) == 1) begin
        w = 0;
      end else begin
        w = $urandom_range(0, 19);
      end
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  task automatic send_item(input stim_row_t t, input bit use_typed, input int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= t.op;
    in_if.slot <= t.slot;
    in_if.val_x <= t.vx;
    in_if.val_y <= t.vy;
    in_if.val_z <= t.vz;
    in_if.coord <= t.coord;
    in_if.pos_x <= t.px;
    in_if.pos_y <= t.py;
    in_if.pos_z <= t.pz;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_interp(t, use_typed);
  endtask

  // stimulus
  initial begin
    stim_row_t t;
    int gap;
    int waited;
    in_if.valid <= 1'b0;
    in_if.operation <= OP_LOAD_CORNER;
    in_if.slot <= '0;
    in_if.val_x <= '0; in_if.val_y <= '0; in_if.val_z <= '0; in_if.coord <= '0;
    in_if.pos_x <= '0; in_if.pos_y <= '0; in_if.pos_z <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: fill the whole store first, every span zero
    for (int i = 0; i < 8; i++)
      dir_rows = {dir_rows,
                  mk(OP_LOAD_CORNER, 3'(i), VMAX[31:0], VMIN[31:0], 32'sh12345, 0, 0, 0, 0)};
    for (int i = 0; i < 6; i++)
      dir_rows = {dir_rows, mk(OP_LOAD_PLANE, 3'(i), 0, 0, 0, 0, 0, 0, 0)};
    // all spans zero: corner 0 passes through with the error flag
    t = mk(OP_QUERY, 0, 0, 0, 0, 0, VMAX[31:0], VMIN[31:0], VMAX[31:0]);
    t.typed = 1'b1; t.ex = VMAX[31:0]; t.ey = VMIN[31:0]; t.ez = 32'sh12345; t.eerr = 1'b1;
    dir_rows = {dir_rows, t};
    // reserved operation and plane slots past the end are ignored
    dir_rows = {dir_rows, mk(OP_RESERVED, 7, -1, -1, -1, -1, -1, -1, -1)};
    dir_rows = {dir_rows, mk(OP_LOAD_PLANE, 6, 0, 0, 0, 32'sh50000, 0, 0, 0)};
    dir_rows = {dir_rows, mk(OP_LOAD_PLANE, 7, 0, 0, 0, VMIN[31:0], 0, 0, 0)};
    // open the spans of columns 0 and 3 and of planes 0-1 and 4-5, then saturate along the way
    dir_rows = {dir_rows,
                mk(OP_LOAD_CORNER, 1, VMIN[31:0], VMAX[31:0], 0, 32'sh10000, 0, 0, 0)};
    dir_rows = {dir_rows, mk(OP_LOAD_CORNER, 7, 1, -1, VMAX[31:0], VMIN[31:0], 0, 0, 0)};
    dir_rows = {dir_rows, mk(OP_LOAD_PLANE, 1, 0, 0, 0, 32'sh10000, 0, 0, 0)};
    dir_rows = {dir_rows, mk(OP_LOAD_PLANE, 5, 0, 0, 0, VMAX[31:0], 0, 0, 0)};
    dir_rows = {dir_rows, mk(OP_QUERY, 0, 0, 0, 0, 0, 32'sh8000, 32'sh8000, 32'sh8000)};
    dir_rows = {dir_rows, mk(OP_QUERY, 0, 0, 0, 0, 0, VMIN[31:0], VMAX[31:0], VMIN[31:0])};
    foreach (dir_rows[i]) send_item(dir_rows[i], dir_rows[i].typed, $urandom_range(0, 3));

    // random traffic with alternating idle behavior
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) begin
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      t = rand_item();
      if (n == RAND_ITEMS / 2) gap = 1;
      else if (((n / 50) % 3) == 2) gap = 0;
      else gap = $urandom_range(0, 19);
      send_item(t, 1'b0, gap);
    end
    in_if.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < IDLE_LIMIT * 4) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
